[rtl/gradient_noise_2d_height_core_macros.svh]
// assertion macros used by the top-level rtl core
`ifndef GRADIENT_NOISE_2D_HEIGHT_CORE_MACROS_SVH
`define GRADIENT_NOISE_2D_HEIGHT_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define GN2H_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gn2h assertion failed");
`define GN2H_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gn2h forbidden condition");
`else
`define GN2H_ASSERT(lbl, clk, rst_n, prop)
`define GN2H_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/gn2h_pkg.sv]
package gn2h_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FB        = FRAC_BITS;
    localparam int DW        = FB + 1;
    localparam int VW        = FB + 4;
    localparam int FW        = FB + 6;
    localparam int PW        = 32 + DW;
    localparam int BW        = VW + 1 + FW;
    localparam int HS        = (FB >= 16) ? (FB - 16) : 0;
    localparam int HL        = (FB < 16) ? (16 - FB) : 0;
    localparam int HW        = VW + HL;

    localparam logic [63:0] HASH_M    = 64'h8803_55f2_1e6d_1965;
    localparam logic [63:0] MIX_K     = 64'h2127_599b_f432_5c37;
    localparam logic [63:0] SEED_MIX  = {HASH_M[60:0], 3'b000};
    localparam logic [63:0] SEED_FLIP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SEED_RST  = 64'd1;
    localparam logic [31:0] G_BIAS    = 32'h8000_0000;

    localparam int MIX_SH_A = 23;
    localparam int MIX_SH_B = 47;

    localparam int H_MAX = 131071;
    localparam int H_MIN = -131072;

    localparam int  PA_W           = 4;
    localparam logic REG_NOISE_SEED = 1'b0;

endpackage

[rtl/gn2h_mul64.sv]
module gn2h_mul64 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_x1;
    logic [31:0] r_x2;
    logic [63:0] r_p;

    // low 64 bits of the product from three partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= 64'(i_a[31:0]) * 64'(i_b[31:0]);
            r_x1 <= i_a[63:32] * i_b[31:0];
            r_x2 <= i_a[31:0] * i_b[63:32];
            r_p  <= r_ll + {r_x1 + r_x2, 32'h0};
        end
    end

    assign o_p = r_p;

endmodule

[rtl/gn2h_hash.sv]
module gn2h_hash
    import gn2h_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [63:0]        i_word,
    input  logic [63:0]        i_seed_a,
    input  logic [63:0]        i_seed_b,
    output logic signed [31:0] o_g0,
    output logic signed [31:0] o_g1
);

    logic [63:0] a1;
    logic [63:0] p;
    logic [63:0] h2;
    logic [63:0] q0;
    logic [63:0] q1;
    logic [63:0] s0;
    logic [63:0] s1;

    assign a1 = i_word ^ (i_word >> MIX_SH_A);

    gn2h_mul64 u_mix (
        .i_clk (i_clk), .i_en (i_en), .i_a (a1), .i_b (MIX_K), .o_p (p)
    );

    assign h2 = p ^ (p >> MIX_SH_B);

    gn2h_mul64 u_seed0 (
        .i_clk (i_clk), .i_en (i_en), .i_a (h2 ^ i_seed_a), .i_b (HASH_M), .o_p (q0)
    );

    gn2h_mul64 u_seed1 (
        .i_clk (i_clk), .i_en (i_en), .i_a (h2 ^ i_seed_b), .i_b (HASH_M), .o_p (q1)
    );

    gn2h_mul64 u_fin0 (
        .i_clk (i_clk), .i_en (i_en), .i_a (q0 ^ (q0 >> MIX_SH_A)), .i_b (MIX_K), .o_p (s0)
    );

    gn2h_mul64 u_fin1 (
        .i_clk (i_clk), .i_en (i_en), .i_a (q1 ^ (q1 >> MIX_SH_A)), .i_b (MIX_K), .o_p (s1)
    );

    // low word of the final mix, re-biased to a signed gradient
    assign o_g0 = $signed(s0[31:0] ^ 32'(s0 >> MIX_SH_B) ^ G_BIAS);
    assign o_g1 = $signed(s1[31:0] ^ 32'(s1 >> MIX_SH_B) ^ G_BIAS);

endmodule

[rtl/gn2h_fade.sv]
module gn2h_fade
    import gn2h_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FB-1:0]        i_s,
    output logic signed [FW-1:0] o_w
);

    localparam logic signed [FW-1:0] C15 = FW'(15 * (2 ** FB));
    localparam logic signed [FW-1:0] C10 = FW'(10 * (2 ** FB));

    logic signed [FW-1:0]    t1;
    logic signed [FW-1:0]    t2;
    logic signed [FW-1:0]    t3;
    logic signed [FW-1:0]    t4;
    logic signed [FW+FB:0]   r_m1;
    logic signed [FW+FB:0]   r_m2;
    logic signed [FW+FB:0]   r_m3;
    logic signed [FW+FB:0]   r_m4;
    logic [FB-1:0]           r_s1;
    logic [FB-1:0]           r_s2;
    logic [FB-1:0]           r_s3;

    // horner steps of 6s^5 - 15s^4 + 10s^3
    always_comb begin
        t1 = $signed(FW'(i_s) * FW'(6)) - C15;
        t2 = FW'(r_m1 >>> FB) + C10;
        t3 = FW'(r_m2 >>> FB);
        t4 = FW'(r_m3 >>> FB);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1 <= t1 * $signed({1'b0, i_s});
            r_s1 <= i_s;
            r_m2 <= t2 * $signed({1'b0, r_s1});
            r_s2 <= r_s1;
            r_m3 <= t3 * $signed({1'b0, r_s2});
            r_s3 <= r_s2;
            r_m4 <= t4 * $signed({1'b0, r_s3});
        end
    end

    assign o_w = FW'(r_m4 >>> FB);

endmodule

[rtl/gradient_noise_2d_height_core.sv]
// channel  | handshake                 | beat payload
// ---------+---------------------------+--------------------------------
// input    | i_in_valid / o_in_stall   | i_x_coord, i_y_coord (q15.16)
// output   | o_out_valid / i_out_stall | o_height (q1.16, saturated)
// config   | apb psel/penable/pready   | noise_seed at byte address 0
//
// one point per cycle while o_in_stall is low
// latency is set by the hash chain: three 64-bit multiplies, two stages each
// reset is synchronous, active low, and puts noise_seed back to 1
// a skid register behind the output holds one beat while the receiver stalls
// o_in_stall rises only when the skid register holds a beat
`include "gradient_noise_2d_height_core_macros.svh"

module gradient_noise_2d_height_core
    import gn2h_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_height,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PA_W-1:0]    paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int NSTG = 14;

    logic                 en;
    logic [63:0]          r_seed;
    logic [63:0]          seed_a;
    logic [63:0]          seed_b;
    logic [NSTG-1:0]      r_v;
    logic signed [31:0]   r_x;
    logic signed [31:0]   r_y;
    logic signed [31:0]   x0;
    logic signed [31:0]   x1;
    logic signed [31:0]   y0;
    logic signed [31:0]   y1;
    logic [63:0]          word  [4];
    logic [63:0]          r_word[4];
    logic [FB-1:0]        r_fxd [1:7];
    logic [FB-1:0]        r_fyd [1:7];
    logic signed [FW-1:0] wx;
    logic signed [FW-1:0] wy;
    logic signed [FW-1:0] r_wxd [6:9];
    logic signed [FW-1:0] r_wyd [6:11];
    logic signed [31:0]   g0    [4];
    logic signed [31:0]   g1    [4];
    logic signed [PW-1:0] r_cp0 [4];
    logic signed [PW-1:0] r_cp1 [4];
    logic signed [PW:0]   cs    [4];
    logic signed [VW-1:0] r_cv  [4];
    logic signed [BW-1:0] r_px0;
    logic signed [BW-1:0] r_px1;
    logic signed [VW-1:0] r_a0;
    logic signed [VW-1:0] r_a1;
    logic signed [VW-1:0] r_ax;
    logic signed [VW-1:0] r_ay;
    logic signed [VW-1:0] r_axd;
    logic signed [BW-1:0] r_py;
    logic signed [VW-1:0] v;
    logic signed [HW-1:0] hv;
    logic signed [17:0]   hsat;
    logic signed [17:0]   r_h;
    logic                 r_ov;
    logic signed [17:0]   r_od;
    logic                 r_sv;
    logic signed [17:0]   r_sd;
    logic                 take;

    assign en     = !r_sv;
    assign take   = !r_ov || !i_out_stall;
    assign seed_a = r_seed ^ SEED_MIX;
    assign seed_b = seed_a ^ SEED_FLIP;

    // lattice corners and their hash words
    always_comb begin
        x0 = r_x >>> FB;
        y0 = r_y >>> FB;
        x1 = x0 + 32'sd1;
        y1 = y0 + 32'sd1;
        for (int c = 0; c < 4; c++) begin
            logic signed [31:0] cx;
            logic signed [31:0] cy;
            cx = ((c % 2) != 0) ? x1 : x0;
            cy = ((c / 2) != 0) ? y1 : y0;
            word[c] = {cy - {31'b0, cx[31]}, cx};
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_corner
        gn2h_hash u_hash (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_word   (r_word[c]),
            .i_seed_a (seed_a),
            .i_seed_b (seed_b),
            .o_g0     (g0[c]),
            .o_g1     (g1[c])
        );
    end

    gn2h_fade u_fade_x (.i_clk (i_clk), .i_en (en), .i_s (r_fxd[1]), .o_w (wx));
    gn2h_fade u_fade_y (.i_clk (i_clk), .i_en (en), .i_s (r_fyd[1]), .o_w (wy));

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            cs[c] = (PW+1)'(r_cp0[c]) + (PW+1)'(r_cp1[c]);
        end
        v  = r_axd + VW'(r_py >>> FB);
        hv = (HW'(v) <<< HL) >>> HS;
        if (hv > H_MAX) begin
            hsat = 18'(H_MAX);
        end else if (hv < H_MIN) begin
            hsat = 18'(H_MIN);
        end else begin
            hsat = 18'(hv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= i_x_coord;
            r_y <= i_y_coord;
            for (int c = 0; c < 4; c++) begin
                r_word[c] <= word[c];
            end
            r_fxd[1] <= r_x[FB-1:0];
            r_fyd[1] <= r_y[FB-1:0];
            for (int k = 2; k <= 7; k++) begin
                r_fxd[k] <= r_fxd[k-1];
                r_fyd[k] <= r_fyd[k-1];
            end
            r_wxd[6] <= wx;
            r_wyd[6] <= wy;
            for (int k = 7; k <= 9; k++) begin
                r_wxd[k] <= r_wxd[k-1];
            end
            for (int k = 7; k <= 11; k++) begin
                r_wyd[k] <= r_wyd[k-1];
            end
            for (int c = 0; c < 4; c++) begin
                r_cp0[c] <= g0[c] * $signed({((c % 2) != 0), r_fxd[7]});
                r_cp1[c] <= g1[c] * $signed({((c / 2) != 0), r_fyd[7]});
                r_cv[c]  <= VW'(cs[c] >>> 31);
            end
            r_px0 <= ((VW+1)'(r_cv[1]) - (VW+1)'(r_cv[0])) * r_wxd[9];
            r_px1 <= ((VW+1)'(r_cv[3]) - (VW+1)'(r_cv[2])) * r_wxd[9];
            r_a0  <= r_cv[0];
            r_a1  <= r_cv[2];
            r_ax  <= r_a0 + VW'(r_px0 >>> FB);
            r_ay  <= r_a1 + VW'(r_px1 >>> FB);
            r_py  <= ((VW+1)'(r_ay) - (VW+1)'(r_ax)) * r_wyd[11];
            r_axd <= r_ax;
            r_h   <= hsat;
        end
        if (take) begin
            r_od <= r_sv ? r_sd : r_h;
        end else if (en) begin
            r_sd <= r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_ov   <= 1'b0;
            r_sv   <= 1'b0;
            r_seed <= SEED_RST;
        end else begin
            if (en) begin
                r_v <= {r_v[NSTG-2:0], i_in_valid};
            end
            if (take) begin
                r_ov <= r_sv || (en && r_v[NSTG-1]);
                r_sv <= 1'b0;
            end else if (en && r_v[NSTG-1]) begin
                r_sv <= 1'b1;
            end
            if (psel && penable && pwrite && paddr[3] == REG_NOISE_SEED) begin
                r_seed <= pwdata;
            end
        end
    end

    assign o_in_stall  = r_sv;
    assign o_out_valid = r_ov;
    assign o_height    = r_od;
    assign pready      = 1'b1;
    assign prdata      = (paddr[3] == REG_NOISE_SEED) ? r_seed : 64'h0;

    `GN2H_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_sv |-> r_ov)
    `GN2H_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_sv) |-> $past(r_ov && i_out_stall))
    `GN2H_ASSERT(a_accept_enters, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> r_v[0])
    `GN2H_ASSERT_NEVER(a_no_drop_at_end, i_clk, i_rst_n, r_sv && r_v[NSTG-1] && !r_ov)

endmodule

[dv/tb_gradient_noise_2d_height_core.sv]
module tb_gradient_noise_2d_height_core;
    import gn2h_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_x_coord;
    logic signed [31:0] i_y_coord;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [17:0] o_height;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PA_W-1:0]    paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    gradient_noise_2d_height_core u_top (.*);

    point_t             point_q[$];
    logic signed [17:0] height_q[$];
    logic [63:0]        seed_now;
    int                 mismatches;
    int                 cycles;
    bit                 quiet;
    int                 hold_left;
    bit                 hold_req;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] mix_word(input logic [63:0] h);
        logic [63:0] t;
        t = h ^ (h >> MIX_SH_A);
        t = t * MIX_K;
        t = t ^ (t >> MIX_SH_B);
        return t;
    endfunction

    function automatic logic [63:0] hash_word(input logic [63:0] w, input logic [63:0] s);
        logic [63:0] h;
        h = s ^ (HASH_M * 64'd8);
        h = h ^ mix_word(w);
        h = h * HASH_M;
        return mix_word(h);
    endfunction

    function automatic longint gradient(input logic [63:0] w, input logic [63:0] s);
        logic [63:0] h;
        h = hash_word(w, s);
        return longint'({32'd0, h[31:0]}) - 64'sd2147483648;
    endfunction

    function automatic longint corner_dot(input longint cx, input longint cy,
                                          input longint dx, input longint dy);
        logic [63:0] w;
        longint      g0;
        longint      g1;
        w  = 64'(cx) + (64'(cy) << 32);
        g0 = gradient(w, seed_now);
        g1 = gradient(w, seed_now ^ SEED_FLIP);
        return (g0 * dx + g1 * dy) >>> 31;
    endfunction

    function automatic longint quintic(input longint s);
        longint t;
        t = 6 * s - 15 * (64'sd1 << FRAC_BITS);
        t = ((t * s) >>> FRAC_BITS) + 10 * (64'sd1 << FRAC_BITS);
        t = (t * s) >>> FRAC_BITS;
        t = (t * s) >>> FRAC_BITS;
        t = (t * s) >>> FRAC_BITS;
        return t;
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint w);
        return a + (((b - a) * w) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [17:0] noise_height(input point_t p);
        longint xs, ys, fx, fy, x0, y0, wx, wy, one;
        longint v00, v10, v01, v11, v, h;
        one = 64'sd1 << FRAC_BITS;
        xs  = longint'(p.x);
        ys  = longint'(p.y);
        fx  = xs & (one - 1);
        fy  = ys & (one - 1);
        x0  = xs >>> FRAC_BITS;
        y0  = ys >>> FRAC_BITS;
        wx  = quintic(fx);
        wy  = quintic(fy);
        v00 = corner_dot(x0, y0, fx, fy);
        v10 = corner_dot(x0 + 1, y0, fx - one, fy);
        v01 = corner_dot(x0, y0 + 1, fx, fy - one);
        v11 = corner_dot(x0 + 1, y0 + 1, fx - one, fy - one);
        v   = lerp(lerp(v00, v10, wx), lerp(v01, v11, wx), wy);
        if (FRAC_BITS >= 16) begin
            h = v >>> HS;
        end else begin
            h = v <<< HL;
        end
        if (h > H_MAX) h = H_MAX;
        if (h < H_MIN) h = H_MIN;
        return h[17:0];
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (point_q.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
                i_in_valid <= 1'b1;
                i_x_coord  <= point_q[0].x;
                i_y_coord  <= point_q[0].y;
                height_q.push_back(noise_height(point_q.pop_front()));
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_req && hold_left == 0) begin
            hold_left   <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            hold_left   <= 0;
            i_out_stall <= !quiet && ($urandom_range(99) < 13);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (height_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected height beat %0d", o_height);
            end else begin
                if (o_height !== height_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("height mismatch: expected %0d, got %0d",
                                 height_q[0], o_height);
                end
                void'(height_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_seed(input logic [63:0] s);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PA_W'(REG_NOISE_SEED);
        pwdata  <= s;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        seed_now = s;
    endtask

    task automatic drain();
        while (point_q.size() > 0 || height_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            2: return {16'($urandom_range(1) ? 16'h7fff : 16'h8000), 16'($urandom)};
            default: return {$urandom_range(1) ? 8'hff : 8'h00, 24'($urandom)};
        endcase
    endfunction

    task automatic add_random(input int n);
        point_t p;
        repeat (n) begin
            p.x = rand_coord();
            p.y = rand_coord();
            point_q.push_back(p);
        end
    endtask

    initial begin
        logic [31:0] edges[8];
        point_t p;
        edges = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                  32'h0000_ffff, 32'h0001_0000, 32'h7fff_8000, 32'h5555_aaaa};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        seed_now = SEED_RST;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners under the reset seed
        for (int i = 0; i < 8; i++) begin
            p.x = edges[i];
            p.y = edges[(i * 3 + 1) % 8];
            point_q.push_back(p);
        end
        p.x = 32'h7fff_ffff; p.y = 32'h7fff_ffff; point_q.push_back(p);
        p.x = 32'h8000_0000; p.y = 32'h8000_0000; point_q.push_back(p);
        drain();

        write_seed(64'd0);
        add_random(150);
        hold_req = 1'b1;
        wait (hold_left != 0);
        hold_req = 1'b0;
        drain();

        write_seed(64'hffff_ffff_ffff_ffff);
        add_random(150);
        drain();

        write_seed({$urandom, $urandom});
        quiet = 1'b1;
        add_random(200);
        drain();
        quiet = 1'b0;

        write_seed(64'h8000_0000_0000_0000);
        add_random(200);
        drain();

        write_seed({$urandom, $urandom});
        add_random(390);
        drain();

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/gn2h_pkg.sv
rtl/gn2h_mul64.sv
rtl/gn2h_hash.sv
rtl/gn2h_fade.sv
rtl/gradient_noise_2d_height_core.sv
dv/tb_gradient_noise_2d_height_core.sv
